[hw/rtl/kwm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the k-way merge min-heap unit.
// No dependencies; every file but kwm_ram uses this package.
package kwm_pkg;

    localparam int MAX_SOURCES = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int SRC_W       = 4;
    localparam int IDX_W       = $clog2(MAX_SOURCES);
    localparam int CNT_W       = $clog2(MAX_SOURCES + 1);

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_BUILD   = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_REMOVE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_LD,
        ST_BLD_RD,
        ST_BLD_LD,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [KEY_WIDTH-1:0] key;
        logic [SRC_W-1:0]     source;
    } item_t;

    typedef struct packed {
        logic                 popped_valid;
        logic [KEY_WIDTH-1:0] popped_key;
        logic [SRC_W-1:0]     popped_source;
        logic                 top_valid;
        logic [SRC_W-1:0]     top_source;
        logic [CNT_W-1:0]     entries_left;
    } result_t;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [SRC_W-1:0]     src;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic in_ready;
        logic latch;
        logic load_wr;
        logic bld_init;
        logic pop_ld;
        logic bld_rd;
        logic bld_ld;
        logic sift_rd;
        logic sift_cmp;
        logic res_load;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t op;
        logic count_zero;
        logic bld_zero;
        logic sift_last;
        logic out_free;
    } stat_t;

endpackage

[hw/rtl/kwm_item_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels for input words and result words.
// Depends on kwm_pkg for the payload types.
interface kwm_item_if;
    logic          valid;
    logic          ready;
    kwm_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kwm_result_if;
    logic            valid;
    logic            ready;
    kwm_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/k_way_merge_min_heap_unit.sv]
`timescale 1ns / 1ps
// Top level of the k-way merge min-heap: controller plus datapath.
// Depends on kwm_pkg, kwm_item_if, kwm_ctrl and kwm_datapath.
//
//   channel  dir  word      fields
//   item     in   item_t    cmd, key, source
//   result   out  result_t  popped_valid/key/source, top_valid/source, entries_left
//
// A load gives no result word. A replace or remove sifts the moved entry down
// by d levels before the result register is loaded (d at most 4 for 16
// entries, a replace sinking to the last leaf); a pop on an empty heap skips
// the sift. The sift loop reads both children from the two-port entry RAM at
// once and compares and writes back in the next cycle. A build runs one such
// sift per inner node, each after a read and a load of that node.
// Reset clears the entry count and the result valid; the entry RAM is not cleared.
// A new word is taken while an earlier result still waits; a stalled result
// only holds the next pop in its final step.
module k_way_merge_min_heap_unit (
    input  logic         clk,
    input  logic         rst_n,
    kwm_item_if.sink     item,
    kwm_result_if.source result
);
    import kwm_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // Ready only while the controller is idle
    assign item.ready = ctrl.in_ready;

    kwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_cmd   (item.data.cmd),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    kwm_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (item.data),
        .ctrl    (ctrl),
        .stat    (stat),
        .result  (result)
    );

endmodule

[hw/rtl/kwm_ram.sv]
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[hw/rtl/kwm_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the merge heap: sequences pop, build and sift steps.
// Depends on kwm_pkg.
module kwm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  kwm_pkg::cmd_t  in_cmd,
    input  kwm_pkg::stat_t stat,
    output kwm_pkg::ctrl_t ctrl
);
    import kwm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_cmd)
                        CMD_LOAD:    state_next = ST_IDLE;
                        CMD_BUILD:   state_next = ST_BLD_RD;
                        CMD_REPLACE: state_next = ST_POP_LD;
                        CMD_REMOVE:  state_next = ST_POP_LD;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POP_LD:   state_next = stat.count_zero ? ST_RESULT : ST_SIFT_RD;
            ST_BLD_RD:   state_next = stat.bld_zero ? ST_IDLE : ST_BLD_LD;
            ST_BLD_LD:   state_next = ST_SIFT_RD;
            ST_SIFT_RD:  state_next = ST_SIFT_CMP;
            ST_SIFT_CMP:
            begin
                if (stat.sift_last)
                begin
                    state_next = (stat.op == CMD_BUILD) ? ST_BLD_RD : ST_RESULT;
                end
                else
                begin
                    state_next = ST_SIFT_RD;
                end
            end
            ST_RESULT:   state_next = stat.out_free ? ST_IDLE : ST_RESULT;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.in_ready = (state_reg == ST_IDLE);
        ctrl.latch    = (state_reg == ST_IDLE) && in_valid;
        ctrl.load_wr  = ctrl.latch && (in_cmd == CMD_LOAD);
        ctrl.bld_init = ctrl.latch && (in_cmd == CMD_BUILD);
        ctrl.pop_ld   = (state_reg == ST_POP_LD);
        ctrl.bld_rd   = (state_reg == ST_BLD_RD);
        ctrl.bld_ld   = (state_reg == ST_BLD_LD);
        ctrl.sift_rd  = (state_reg == ST_SIFT_RD);
        ctrl.sift_cmp = (state_reg == ST_SIFT_CMP);
        ctrl.res_load = (state_reg == ST_RESULT) && stat.out_free;
    end

endmodule

[hw/rtl/kwm_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the merge heap: entry store, sift registers and result register.
// Depends on kwm_pkg, kwm_item_if and kwm_ram.
module kwm_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  kwm_pkg::item_t in_data,
    input  kwm_pkg::ctrl_t ctrl,
    output kwm_pkg::stat_t stat,
    kwm_result_if.source   result
);
    import kwm_pkg::*;

    localparam int CHILD_W = IDX_W + 2;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [IDX_W-1:0]     bld_i_reg;
    logic [IDX_W-1:0]     pos_reg;
    entry_t               cur_reg;
    cmd_t                 op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 pvalid_reg;
    logic [KEY_WIDTH-1:0] pkey_reg;
    logic [SRC_W-1:0]     psrc_reg;
    logic [SRC_W-1:0]     top_src_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;

    logic                 we;
    logic [IDX_W-1:0]     waddr;
    entry_t               wdata;
    logic [IDX_W-1:0]     raddr_a;
    logic [IDX_W-1:0]     raddr_b;
    entry_t               rd_a;
    entry_t               rd_b;

    logic [CHILD_W-1:0]   lidx;
    logic [CHILD_W-1:0]   ridx;
    logic                 l_ok;
    logic                 r_ok;
    logic                 take_l;
    logic                 take_r;
    logic [KEY_WIDTH-1:0] best_key;
    entry_t               child;
    logic [IDX_W-1:0]     child_idx;

    kwm_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_SOURCES)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Child positions of the current hole
    assign lidx = {1'b0, pos_reg, 1'b1};
    assign ridx = lidx + 1'b1;
    assign l_ok = lidx < CHILD_W'(count_reg);
    assign r_ok = ridx < CHILD_W'(count_reg);

    // Strict less-than; the left child wins a tie
    always_comb
    begin
        take_l   = l_ok && (rd_a.key < cur_reg.key);
        best_key = take_l ? rd_a.key : cur_reg.key;
        take_r   = r_ok && (rd_b.key < best_key);
        child    = take_r ? rd_b : rd_a;
        child_idx = take_r ? ridx[IDX_W-1:0] : lidx[IDX_W-1:0];
    end

    // Read address selection: pop reads top and last while idle
    always_comb
    begin
        raddr_a = '0;
        raddr_b = IDX_W'(count_reg - 1'b1);
        if (ctrl.bld_rd)
        begin
            raddr_a = bld_i_reg - 1'b1;
        end
        else if (ctrl.sift_rd)
        begin
            raddr_a = lidx[IDX_W-1:0];
            raddr_b = ridx[IDX_W-1:0];
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = (take_l || take_r) ? child : cur_reg;
        if (ctrl.load_wr)
        begin
            we    = count_reg < CNT_W'(MAX_SOURCES);
            waddr = count_reg[IDX_W-1:0];
            wdata = '{key: in_data.key, src: in_data.source};
        end
        else if (ctrl.sift_cmp)
        begin
            we = 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.load_wr && (count_reg < CNT_W'(MAX_SOURCES)))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop_ld && (op_reg == CMD_REMOVE) && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (ctrl.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            op_reg  <= in_data.cmd;
            key_reg <= in_data.key;
        end
        if (ctrl.bld_init)
        begin
            bld_i_reg <= IDX_W'(count_reg >> 1);
        end
        if (ctrl.pop_ld)
        begin
            pos_reg     <= '0;
            top_src_reg <= '0;
            if (count_reg == '0)
            begin
                pvalid_reg <= 1'b0;
                pkey_reg   <= '0;
                psrc_reg   <= '0;
            end
            else
            begin
                pvalid_reg <= 1'b1;
                pkey_reg   <= rd_a.key;
                psrc_reg   <= rd_a.src;
                cur_reg    <= (op_reg == CMD_REPLACE) ?
                              entry_t'{key: key_reg, src: rd_a.src} : rd_b;
            end
        end
        if (ctrl.bld_ld)
        begin
            cur_reg   <= rd_a;
            pos_reg   <= bld_i_reg - 1'b1;
            bld_i_reg <= bld_i_reg - 1'b1;
        end
        if (ctrl.sift_cmp)
        begin
            if (pos_reg == '0)
            begin
                top_src_reg <= wdata.src;
            end
            if (take_l || take_r)
            begin
                pos_reg <= child_idx;
            end
        end
        if (ctrl.res_load)
        begin
            out_data_reg.popped_valid  <= pvalid_reg;
            out_data_reg.popped_key    <= pkey_reg;
            out_data_reg.popped_source <= psrc_reg;
            out_data_reg.top_valid     <= (count_reg != '0);
            out_data_reg.top_source    <= (count_reg != '0) ? top_src_reg : '0;
            out_data_reg.entries_left  <= count_reg;
        end
    end

    assign stat.op         = op_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.bld_zero   = (bld_i_reg == '0);
    assign stat.sift_last  = !(take_l || take_r);
    assign stat.out_free   = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

[hw/rtl/kwm_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the merge heap unit, attached by bind.
// Depends on kwm_pkg and k_way_merge_min_heap_unit.
module kwm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input kwm_pkg::item_t   item_data,
    input logic             res_valid,
    input logic             res_ready,
    input kwm_pkg::result_t res_data
);
    import kwm_pkg::*;

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result word changed while stalled");

    // Any word but a load leaves the unit not ready in the cycle after it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_data.cmd != CMD_LOAD) |=> !item_ready)
        else $error("unit ready right after a build or pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.top_valid == (res_data.entries_left != '0))
                      && (res_data.entries_left <= CNT_W'(MAX_SOURCES)))
        else $error("top_valid disagrees with entries_left");

    // An empty pop reports an empty heap with cleared fields
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.popped_valid |->
            (res_data.entries_left == '0) && (res_data.popped_key == '0)
            && (res_data.popped_source == '0))
        else $error("empty pop with nonempty heap or stale fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.top_valid |-> (res_data.top_source == '0))
        else $error("top_source set on an empty heap");

endmodule

bind k_way_merge_min_heap_unit kwm_checker u_kwm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_data  (item.data),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_data   (result.data)
);
